// ===== sv/pla_pkg.sv =====
`default_nettype none

package pla_pkg;

    // item function codes
    localparam logic [1:0] FUNC_HIT     = 2'd0;
    localparam logic [1:0] FUNC_SURFACE = 2'd1;
    localparam logic [1:0] FUNC_LIGHT   = 2'd2;
    localparam logic [1:0] FUNC_MISS    = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_BG_RED    = 3'd0;
    localparam logic [2:0] CFG_BG_GREEN  = 3'd1;
    localparam logic [2:0] CFG_BG_BLUE   = 3'd2;
    localparam logic [2:0] CFG_SPEC_GAIN = 3'd3;
    localparam logic [2:0] CFG_DIFF_GAIN = 3'd4;

    localparam logic [15:0] SPEC_GAIN_RST = 16'd179;
    localparam logic [15:0] DIFF_GAIN_RST = 16'd102;

    // fixed point constants
    localparam logic [14:0] ONE_Q14  = 15'd16384;
    localparam logic [1:0]  COMP_LAST = 2'd2;

    // shared multiplier operand widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // isqrt: 50-bit radicand, 25-bit root
    localparam int SQ_W   = 50;
    localparam int ROOT_W = 25;

    // divider: 39-bit numerator, 15-bit quotient
    localparam int NUM_W = 39;
    localparam int QUO_W = 15;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQ_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_NL,
        ST_NL_ACC,
        ST_R,
        ST_R_ACC,
        ST_RV,
        ST_RV_ACC,
        ST_POW,
        ST_POW_ACC,
        ST_SPEC,
        ST_SPEC_ACC,
        ST_TERM1,
        ST_TERM1_ACC,
        ST_TERM2,
        ST_TERM2_ACC,
        ST_FIN
    } st_t;

endpackage

`default_nettype wire

// ===== sv/pla_mul.sv =====
`default_nettype none

module pla_mul
    import pla_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic signed [MUL_A_W-1:0]  a,
    input  wire logic signed [MUL_B_W-1:0]  b,
    output logic signed [MUL_P_W-1:0]       prod_reg
);

    // registered signed product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

`default_nettype wire

// ===== sv/pla_isqrt.sv =====
`default_nettype none

module pla_isqrt
    import pla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   x,
    output logic                   done_reg,
    output logic [ROOT_W-1:0]      root_reg
);

    logic [SQ_W-1:0]   x_reg;
    logic [ROOT_W+2:0] rem_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;

    // one root bit per cycle
    assign rem_sh = {rem_reg[ROOT_W:0], x_reg[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/pla_div.sv =====
`default_nettype none

module pla_div
    import pla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [ROOT_W-1:0] den,
    output logic                   done_reg,
    output logic [QUO_W-1:0]       quo_reg
);

    logic [ROOT_W:0]   rem_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [3:0]        cnt_reg;
    logic              busy_reg;
    logic [ROOT_W:0]   rem_sh;

    // restoring division, quotient known to fit in QUO_W bits
    assign rem_sh = {rem_reg[ROOT_W-1:0], low_reg[QUO_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= (ROOT_W+1)'(num[NUM_W-1:QUO_W]);
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/phong_light_accumulate.sv =====
`default_nettype none
// Phong point-light shading of one ray hit.
// Input channel (in_valid / in_stall): func selects hit, surface, light or
// miss. A hit item loads the hit point and base color and gives no result.
// A surface item loads normal and view vector; a light item adds its
// contribution; either gives the shaded color when last_light is set.
// A miss item gives the background color with was_miss set.
// Output channel (out_valid / out_stall) is a single output register.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high.
// An unshadowed light item uses a square root, three divides and the chain
// of products on the one shared multiplier. in_stall is high while an item
// is in work.
// When out_stall holds a result, the next result waits in the last step
// until the output register is free; no result is dropped.
// Reset clears all state and colors to zero, background to zero and the
// gains to 0.7 and 0.4.
module phong_light_accumulate
    import pla_pkg::*;
#(
    parameter int SPECULAR_EXPONENT = 10
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         func,
    input  wire logic signed [23:0] vec_x,
    input  wire logic signed [23:0] vec_y,
    input  wire logic signed [23:0] vec_z,
    input  wire logic signed [16:0] aux_x,
    input  wire logic signed [16:0] aux_y,
    input  wire logic signed [16:0] aux_z,
    input  wire logic [15:0]        intensity,
    input  wire logic               shadowed,
    input  wire logic               last_light,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             red,
    output logic [15:0]             green,
    output logic [15:0]             blue,
    output logic                    was_miss,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int KW = $clog2(SPECULAR_EXPONENT + 1);
    localparam logic [KW-1:0] K_LAST = KW'(SPECULAR_EXPONENT - 1);

    st_t state_reg, state_next;

    logic [15:0] bg_reg [3];
    logic [15:0] ks_reg, kd_reg;

    logic signed [23:0] hit_reg   [3];
    logic signed [15:0] nrm_reg   [3];
    logic signed [15:0] view_reg  [3];
    logic [15:0]        color_reg [3];

    logic signed [24:0] d_reg [3];
    logic signed [15:0] l_reg [3];
    logic signed [21:0] r_reg [3];
    logic [1:0]         idx_reg;
    logic [15:0]        illum_reg;
    logic               emit_reg, miss_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [ROOT_W-1:0]  len_reg;
    logic signed [33:0] nl_reg;
    logic [17:0]        ndl_reg;
    logic signed [39:0] rv_reg;
    logic [14:0]        rdv_reg;
    logic [14:0]        p_reg;
    logic [KW-1:0]      k_reg;
    logic [16:0]        coeff_reg;
    logic [32:0]        acoef_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic                      sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]         sqrt_root;
    logic                      div_start, div_done;
    logic [QUO_W-1:0]          div_quo;
    logic [NUM_W-1:0]          div_num;

    logic                in_xfer;
    logic signed [23:0]  vec_in [3];
    logic signed [16:0]  aux_in [3];
    logic signed [24:0]  d_sel, d_neg;
    logic signed [33:0]  nl_sum, nl_rnd;
    logic                nl_pos;
    logic signed [34:0]  r_t;
    logic signed [21:0]  r_new;
    logic signed [39:0]  rv_sum, rv_rnd;
    logic                rv_pos;
    logic [14:0]         rdv_new;
    logic [29:0]         pow_t;
    logic [30:0]         spec_t;
    logic [51:0]         term_t;
    logic [29:0]         term;
    logic                out_load;

    assign vec_in[0] = vec_x;
    assign vec_in[1] = vec_y;
    assign vec_in[2] = vec_z;
    assign aux_in[0] = aux_x;
    assign aux_in[1] = aux_y;
    assign aux_in[2] = aux_z;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // shared arithmetic units
    pla_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    pla_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .x        (sq_reg),
        .done_reg (sqrt_done),
        .root_reg (sqrt_root)
    );

    pla_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (len_reg),
        .done_reg (div_done),
        .quo_reg  (div_quo)
    );

    // per-step combinational values
    always_comb
    begin
        d_sel   = d_reg[idx_reg];
        d_neg   = -d_sel;
        div_num = {d_sel[24] ? d_neg[23:0] : d_sel[23:0], 14'b0}
                  + NUM_W'(len_reg[ROOT_W-1:1]);
        nl_sum  = nl_reg + $signed(prod_reg[33:0]);
        nl_pos  = !nl_sum[33] && (nl_sum != '0);
        nl_rnd  = nl_sum + 34'sd8192;
        r_t     = $signed({prod_reg[33:0], 1'b0}) + 35'sd8192;
        r_new   = $signed({r_t[34], r_t[34:14]})
                  - $signed({{6{l_reg[idx_reg][15]}}, l_reg[idx_reg]});
        rv_sum  = rv_reg + $signed(prod_reg[39:0]);
        rv_pos  = !rv_sum[39] && (rv_sum != '0);
        rv_rnd  = rv_sum + 40'sd8192;
        rdv_new = (rv_rnd[39:14] > 26'(ONE_Q14)) ? ONE_Q14 : rv_rnd[28:14];
        pow_t   = prod_reg[29:0] + 30'd8192;
        spec_t  = prod_reg[30:0] + 31'd8192;
        term_t  = prod_reg[51:0] + 52'd2097152;
        term    = term_t[51:22];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (func)
                        FUNC_HIT:     state_next = ST_IDLE;
                        FUNC_SURFACE: state_next = last_light ? ST_FIN : ST_IDLE;
                        FUNC_LIGHT:   state_next = shadowed ? ST_FIN : ST_SQ;
                        FUNC_MISS:    state_next = ST_FIN;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SQ:        state_next = ST_SQ_ACC;
            ST_SQ_ACC:    state_next = (idx_reg == COMP_LAST) ? ST_SQRT_GO : ST_SQ;
            ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                    state_next = (sqrt_root == '0) ? ST_FIN : ST_DIV_GO;
            end
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (idx_reg == COMP_LAST) ? ST_NL : ST_DIV_GO;
            end
            ST_NL:        state_next = ST_NL_ACC;
            ST_NL_ACC:
            begin
                if (idx_reg != COMP_LAST)
                    state_next = ST_NL;
                else
                    state_next = nl_pos ? ST_R : ST_FIN;
            end
            ST_R:         state_next = ST_R_ACC;
            ST_R_ACC:     state_next = (idx_reg == COMP_LAST) ? ST_RV : ST_R;
            ST_RV:        state_next = ST_RV_ACC;
            ST_RV_ACC:
            begin
                if (idx_reg != COMP_LAST)
                    state_next = ST_RV;
                else
                    state_next = rv_pos ? ST_POW : ST_SPEC;
            end
            ST_POW:       state_next = ST_POW_ACC;
            ST_POW_ACC:   state_next = (k_reg == K_LAST) ? ST_SPEC : ST_POW;
            ST_SPEC:      state_next = ST_SPEC_ACC;
            ST_SPEC_ACC:  state_next = ST_TERM1;
            ST_TERM1:     state_next = ST_TERM1_ACC;
            ST_TERM1_ACC: state_next = ST_TERM2;
            ST_TERM2:     state_next = ST_TERM2_ACC;
            ST_TERM2_ACC: state_next = ST_FIN;
            ST_FIN:
            begin
                if (!emit_reg || !out_valid || !out_stall)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // unit controls and multiplier operands
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        sqrt_start = (state_reg == ST_SQRT_GO);
        div_start  = (state_reg == ST_DIV_GO);
        out_load   = (state_reg == ST_FIN) && emit_reg && (!out_valid || !out_stall);
        case (state_reg)
            ST_SQ:
            begin
                mul_a = MUL_A_W'(d_sel);
                mul_b = MUL_B_W'(d_sel);
            end
            ST_NL:
            begin
                mul_a = MUL_A_W'(nrm_reg[idx_reg]);
                mul_b = MUL_B_W'(l_reg[idx_reg]);
            end
            ST_R:
            begin
                mul_a = MUL_A_W'(nrm_reg[idx_reg]);
                mul_b = $signed({8'b0, ndl_reg});
            end
            ST_RV:
            begin
                mul_a = MUL_A_W'(r_reg[idx_reg]);
                mul_b = MUL_B_W'(view_reg[idx_reg]);
            end
            ST_POW:
            begin
                mul_a = $signed({19'b0, p_reg});
                mul_b = $signed({11'b0, rdv_reg});
            end
            ST_SPEC:
            begin
                mul_a = $signed({18'b0, ks_reg});
                mul_b = $signed({11'b0, p_reg});
            end
            ST_TERM1:
            begin
                mul_a = $signed({17'b0, coeff_reg});
                mul_b = $signed({10'b0, illum_reg});
            end
            ST_TERM2:
            begin
                mul_a = $signed({1'b0, acoef_reg});
                mul_b = $signed({8'b0, ndl_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg[0] <= '0;
            bg_reg[1] <= '0;
            bg_reg[2] <= '0;
            ks_reg    <= SPEC_GAIN_RST;
            kd_reg    <= DIFF_GAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BG_RED:    bg_reg[0] <= cfg_data;
                CFG_BG_GREEN:  bg_reg[1] <= cfg_data;
                CFG_BG_BLUE:   bg_reg[2] <= cfg_data;
                CFG_SPEC_GAIN: ks_reg    <= cfg_data;
                CFG_DIFF_GAIN: kd_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    // shading state: hit point, normal, view and running color
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hit_reg[i]   <= '0;
                nrm_reg[i]   <= '0;
                view_reg[i]  <= '0;
                color_reg[i] <= '0;
            end
        end
        else if (in_xfer && (func == FUNC_HIT))
        begin
            for (int i = 0; i < 3; i++)
            begin
                hit_reg[i]   <= vec_in[i];
                color_reg[i] <= aux_in[i][16] ? 16'd0 : aux_in[i][15:0];
            end
        end
        else if (in_xfer && (func == FUNC_SURFACE))
        begin
            for (int i = 0; i < 3; i++)
            begin
                // saturate normal and negated ray direction to 16 bits
                if (vec_in[i] > 24'sd32767)
                    nrm_reg[i] <= 16'sh7FFF;
                else if (vec_in[i] < -24'sd32768)
                    nrm_reg[i] <= 16'sh8000;
                else
                    nrm_reg[i] <= vec_in[i][15:0];
                if (aux_in[i] < -17'sd32767)
                    view_reg[i] <= 16'sh7FFF;
                else if (aux_in[i] > 17'sd32768)
                    view_reg[i] <= 16'sh8000;
                else
                    view_reg[i] <= 16'(-aux_in[i]);
            end
        end
        else if (state_reg == ST_TERM2_ACC)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ((31'(color_reg[i]) + 31'(term)) > 31'd65535)
                    color_reg[i] <= 16'hFFFF;
                else
                    color_reg[i] <= color_reg[i] + term[15:0];
            end
        end
    end

    // item control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            emit_reg <= 1'b0;
            miss_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                idx_reg  <= '0;
                emit_reg <= (func == FUNC_MISS) || ((func != FUNC_HIT) && last_light);
                miss_reg <= (func == FUNC_MISS);
            end
            case (state_reg)
                ST_SQ_ACC, ST_NL_ACC, ST_R_ACC, ST_RV_ACC:
                    idx_reg <= (idx_reg == COMP_LAST) ? 2'd0 : idx_reg + 2'd1;
                ST_DIV_WAIT:
                begin
                    if (div_done)
                        idx_reg <= (idx_reg == COMP_LAST) ? 2'd0 : idx_reg + 2'd1;
                end
                ST_SQRT_WAIT:
                    idx_reg <= '0;
                ST_POW:
                    k_reg <= k_reg;
                ST_POW_ACC:
                    k_reg <= k_reg + KW'(1);
                default:
                    ;
            endcase
            if (state_reg == ST_RV_ACC)
                k_reg <= '0;
        end
    end

    // light datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int i = 0; i < 3; i++)
                d_reg[i] <= {vec_in[i][23], vec_in[i]} - {hit_reg[i][23], hit_reg[i]};
            illum_reg <= intensity;
            sq_reg    <= '0;
            nl_reg    <= '0;
            rv_reg    <= '0;
        end
        case (state_reg)
            ST_SQ_ACC:
                sq_reg <= sq_reg + prod_reg[SQ_W-1:0];
            ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                    len_reg <= sqrt_root;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    l_reg[idx_reg] <= d_sel[24] ? -$signed({1'b0, div_quo})
                                                :  $signed({1'b0, div_quo});
            end
            ST_NL_ACC:
            begin
                nl_reg  <= nl_sum;
                ndl_reg <= nl_rnd[31:14];
            end
            ST_R_ACC:
                r_reg[idx_reg] <= r_new;
            ST_RV_ACC:
            begin
                rv_reg  <= rv_sum;
                rdv_reg <= rdv_new;
                p_reg   <= rv_pos ? ONE_Q14 : 15'd0;
            end
            ST_POW_ACC:
                p_reg <= pow_t[28:14];
            ST_SPEC_ACC:
                coeff_reg <= {1'b0, spec_t[29:14]} + {1'b0, kd_reg};
            ST_TERM1_ACC:
                acoef_reg <= prod_reg[32:0];
            default:
                ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red      <= miss_reg ? bg_reg[0] : color_reg[0];
            green    <= miss_reg ? bg_reg[1] : color_reg[1];
            blue     <= miss_reg ? bg_reg[2] : color_reg[2];
            was_miss <= miss_reg;
        end
    end

endmodule

`default_nettype wire
